// File: src/char_lcd_register_controller_core_macros.svh
// Assertion macros for the character display register block.
// Used by the top level; needs clk and rst in the including scope.
`ifndef CHAR_LCD_REGISTER_CONTROLLER_CORE_MACROS_SVH
`define CHAR_LCD_REGISTER_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CLCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define CLCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/clcd_pkg.sv
// Shared types and constants for the character display register block.
// No dependencies.
`timescale 1ns / 1ps

package clcd_pkg;

  // Item kinds
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Register window offsets
  localparam logic [11:0] OFS_RESET  = 12'h050;
  localparam logic [11:0] OFS_CTL    = 12'h400;
  localparam logic [11:0] OFS_DATA   = 12'h408;
  localparam logic [11:0] OFS_STATUS = 12'h410;

  localparam logic [31:0] RESET_MAGIC = 32'h0000_004d;
  localparam logic [7:0]  SPACE_CHAR  = 8'h20;

  // Control byte bit positions
  localparam int CTL_CLEAR = 0;
  localparam int CTL_HOME  = 1;
  localparam int CTL_LINE  = 6;
  localparam int CTL_PLACE = 7;

  localparam int TEXT_LEN = 16 * 2;
  localparam int POS_W    = $clog2(TEXT_LEN);

  // Status toggle half period in ticks
  localparam int PHASE_MS = 10;
  localparam int PHASE_W  = (PHASE_MS > 1) ? $clog2(PHASE_MS) : 1;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASE_MS - 1);

  typedef struct packed {
    logic [7:0]       display_char;
    logic [POS_W-1:0] display_pos;
    logic             display_write;
    logic             reset_request;
    logic [7:0]       read_data;
  } clcd_result_t;

endpackage

// File: src/clcd_regs.sv
// Register state of the display block: text store, cursor, latches, tick counter.
// Depends on clcd_pkg.
`timescale 1ns / 1ps

module clcd_regs import clcd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [1:0]   action,
  input  logic [11:0]  reg_offset,
  input  logic [31:0]  write_data,
  output clcd_result_t result
);

  logic [7:0]       text_store [TEXT_LEN];
  logic [POS_W-1:0] cursor;
  logic [7:0]       control_latch;
  logic [7:0]       data_latch;
  logic [PHASE_W-1:0] ms_phase_count;
  logic             phase_bit;

  logic [7:0]       wbyte;
  logic             is_wr, ctl_wr, data_wr, tick;
  logic             clear_all;
  logic [POS_W-1:0] cursor_next;
  logic [7:0]       ctl_char;

  assign wbyte   = write_data[7:0];
  assign is_wr   = (action == ACT_WRITE);
  assign ctl_wr  = is_wr && (reg_offset == OFS_CTL);
  assign data_wr = is_wr && (reg_offset == OFS_DATA);
  assign tick    = (action == ACT_TICK);

  // Work out cursor and latched character for a control write
  always_comb begin
    clear_all   = 1'b0;
    cursor_next = cursor;
    if (wbyte[CTL_PLACE]) begin
      cursor_next = {wbyte[CTL_LINE], wbyte[3:0]};
    end else begin
      clear_all = wbyte[CTL_CLEAR];
      if (wbyte[CTL_HOME]) begin
        cursor_next = '0;
      end
    end
    ctl_char = clear_all ? SPACE_CHAR : text_store[cursor_next];
  end

  // Form the result of the current item
  always_comb begin
    result = '0;
    case (action)
      ACT_READ: begin
        case (reg_offset)
          OFS_CTL:    result.read_data = control_latch;
          OFS_DATA:   result.read_data = data_latch;
          OFS_STATUS: result.read_data = {6'd0, phase_bit, 1'b0};
          default:    result.read_data = '0;
        endcase
      end
      ACT_WRITE: begin
        result.reset_request = (reg_offset == OFS_RESET) && (write_data == RESET_MAGIC);
        if (data_wr) begin
          result.display_write = 1'b1;
          result.display_pos   = cursor;
          result.display_char  = wbyte;
        end
      end
      default: result = '0;
    endcase
  end

  // Update text store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TEXT_LEN; i++) text_store[i] <= SPACE_CHAR;
    end else if (accept && ctl_wr && clear_all) begin
      for (int i = 0; i < TEXT_LEN; i++) text_store[i] <= SPACE_CHAR;
    end else if (accept && data_wr) begin
      text_store[cursor] <= wbyte;
    end
  end

  // Update cursor, latches and tick counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor         <= '0;
      control_latch  <= '0;
      data_latch     <= '0;
      ms_phase_count <= '0;
      phase_bit      <= 1'b0;
    end else if (accept) begin
      if (ctl_wr) begin
        control_latch <= wbyte;
        cursor        <= cursor_next;
        data_latch    <= ctl_char;
      end else if (data_wr) begin
        data_latch <= wbyte;
        cursor     <= cursor + 1'b1;
      end else if (tick) begin
        if (ms_phase_count == PHASE_LAST) begin
          ms_phase_count <= '0;
          phase_bit      <= ~phase_bit;
        end else begin
          ms_phase_count <= ms_phase_count + 1'b1;
        end
      end
    end
  end

endmodule

// File: src/char_lcd_register_controller_core.sv
// Character display register block: stream ports, output register and skid stage.
// The result of an item is registered onto m_tdata, through the skid stage if the output register is stalled.
// Throughput: one item per cycle while s_tready is high; a second item is held in the skid stage
// while the output register is stalled, and s_tready drops only when both are full.
// Reset (rst, synchronous): cursor, latches, tick count cleared, all 32 text
// positions set to space in the reset cycle; no output items pending.
// Depends on clcd_pkg, clcd_regs and char_lcd_register_controller_core_macros.svh.
`timescale 1ns / 1ps
`include "char_lcd_register_controller_core_macros.svh"

module char_lcd_register_controller_core import clcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // reg_offset[11:0], write_data[43:12], zero pad[47:44]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // read_data[7:0], reset_request[8], display_write[9],
                                 // display_pos[14:10], display_char[22:15], zero pad[23]
);

  logic         accept;
  clcd_result_t res;
  clcd_result_t out_res, skid_res;
  logic         out_valid, skid_valid;
  logic         out_free;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  clcd_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .action     (s_tuser),
    .reg_offset (s_tdata[11:0]),
    .write_data (s_tdata[43:12]),
    .result     (res)
  );

  // Advance output register and skid stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Move payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (accept) begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res.display_char, out_res.display_pos,
                     out_res.display_write, out_res.reset_request, out_res.read_data};

  `CLCD_ASSERT_NOW(a_skid_needs_out, skid_valid, out_valid, "skid full while output empty")
  `CLCD_ASSERT_NEXT(a_stall_fills_skid, out_valid && !m_tready && accept, skid_valid, "stalled item lost")
  `CLCD_ASSERT_NOW(a_disp_no_read, m_tvalid && m_tdata[9], m_tdata[7:0] == 8'd0, "display item with read data")
  `CLCD_ASSERT_NEXT(a_drain_skid, skid_valid && m_tready, !skid_valid && out_valid, "skid not drained")

endmodule
